// ===== sv/bcfc_pkg.sv =====
// Shared types and constants for the banded circulant fully connected unit.
// Used by the channel interfaces, front end, command queue and back end.
// No dependencies.
package bcfc_pkg;

  // Field widths fixed by the item format
  localparam int OPC_W   = 2;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int Q88_W   = 16;
  localparam int LEN_W   = 7;
  localparam int CFG_A_W = 2;

  // Accumulator: 127 products of 2^30 plus a 32-bit bias fit in 40 bits
  localparam int ACC_W = 40;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OPC_W-1:0] OP_BIAS   = 2'd1;
  localparam logic [OPC_W-1:0] OP_ACT    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_IN_LEN     = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_OUT_LEN    = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_WINDOW_LEN = 2'd2;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_ACT
  } cmd_kind_t;

  // One queued command
  typedef struct packed {
    cmd_kind_t         kind;
    logic              wr_en;
    logic              start;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

// ===== sv/bcfc_in_if.sv =====
// Input request channel: valid/ready handshake plus load request payload.
// Depends on bcfc_pkg for field widths.
interface bcfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bcfc_pkg::OPC_W-1:0]    opcode;
  logic [bcfc_pkg::IDX_W-1:0]    row_index;
  logic [bcfc_pkg::IDX_W-1:0]    col_index;
  logic signed [bcfc_pkg::VAL_W-1:0] value;
  logic                          row_done;

  modport source (
    output valid, opcode, row_index, col_index, value, row_done,
    input  ready
  );
  modport sink (
    input  valid, opcode, row_index, col_index, value, row_done,
    output ready
  );
endinterface

// ===== sv/bcfc_out_if.sv =====
// Result channel: valid/ready handshake plus one neuron result.
// Depends on bcfc_pkg for field widths.
interface bcfc_out_if;
  logic                              valid;
  logic                              ready;
  logic [bcfc_pkg::IDX_W-1:0]        out_index;
  logic signed [bcfc_pkg::VAL_W-1:0] out_value;
  logic                              out_last;

  modport source (
    output valid, out_index, out_value, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_index, out_value, out_last,
    output ready
  );
endinterface

// ===== sv/bcfc_front.sv =====
// Front end: accepts requests, checks index ranges and classifies them into
// queue commands. Depends on bcfc_pkg and bcfc_in_if.
module bcfc_front #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  bcfc_in_if.sink        in_req,
  input  logic           q_full,
  output logic           q_push,
  output bcfc_pkg::cmd_t q_cmd
);

  logic row_ok;
  logic col_ok;
  logic keep;

  // Range checks against the store sizes
  assign row_ok = int'(in_req.row_index) < MAX_IN;
  assign col_ok = int'(in_req.col_index) < MAX_OUT;

  // Classify the request; drop what has no effect
  always_comb begin
    q_cmd.kind  = bcfc_pkg::CMD_ACT;
    q_cmd.wr_en = 1'b0;
    q_cmd.start = 1'b0;
    q_cmd.row   = in_req.row_index;
    q_cmd.col   = in_req.col_index;
    q_cmd.value = in_req.value;
    keep        = 1'b0;
    unique case (in_req.opcode)
      bcfc_pkg::OP_WEIGHT: begin
        q_cmd.kind  = bcfc_pkg::CMD_WEIGHT;
        q_cmd.wr_en = row_ok && col_ok;
        keep        = row_ok && col_ok;
      end
      bcfc_pkg::OP_BIAS: begin
        q_cmd.kind  = bcfc_pkg::CMD_BIAS;
        q_cmd.wr_en = col_ok;
        keep        = col_ok;
      end
      bcfc_pkg::OP_ACT: begin
        q_cmd.kind  = bcfc_pkg::CMD_ACT;
        q_cmd.wr_en = row_ok;
        q_cmd.start = in_req.row_done;
        keep        = row_ok || in_req.row_done;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Accept whenever the queue has room
  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid && !q_full && keep;

endmodule

// ===== sv/bcfc_queue.sv =====
// Short command queue between front and back end.
// Depends on bcfc_pkg for the command type and depth.
module bcfc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bcfc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output bcfc_pkg::cmd_t head,
  output logic           empty
);

  bcfc_pkg::cmd_t                     slots_r [bcfc_pkg::QUEUE_DEPTH];
  logic [bcfc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [bcfc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [bcfc_pkg::QUEUE_CNT_W-1:0]   count_r;
  logic [bcfc_pkg::QUEUE_CNT_W-1:0]   count_nxt;

  assign full  = count_r == bcfc_pkg::QUEUE_CNT_W'(bcfc_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue popped while empty");

endmodule

// ===== sv/bcfc_back.sv =====
// Back end: applies store writes, sequences the banded multiply-accumulate
// per neuron, saturates and holds the result register.
// Depends on bcfc_pkg and bcfc_out_if.
module bcfc_back #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bcfc_pkg::LEN_W-1:0]   in_len,
  input  logic [bcfc_pkg::LEN_W-1:0]   out_len,
  input  logic [bcfc_pkg::LEN_W-1:0]   window_len,
  input  logic                         q_empty,
  input  bcfc_pkg::cmd_t               q_head,
  output logic                         q_pop,
  bcfc_out_if.source                   out_res
);

  localparam int IN_W     = $clog2(MAX_IN);
  localparam int OUT_W    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WT_DEPTH = MAX_IN * (1 << OUT_W);
  localparam int WT_AW    = IN_W + OUT_W;
  localparam int LW       = bcfc_pkg::LEN_W;
  localparam int XW       = 16;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Slot tag carried along the pipeline
  typedef struct packed {
    logic                       first;
    logic                       last;
    logic                       row_last;
    logic                       zero;
    logic [bcfc_pkg::IDX_W-1:0] o;
  } tag_t;

  function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] x,
                                             input logic [LW-1:0] n);
    logic [LW:0] s;
    s = {1'b0, x} + 1'b1;
    return (s == {1'b0, n}) ? '0 : s[LW-1:0];
  endfunction

  // Stores
  logic signed [bcfc_pkg::Q88_W-1:0] wt_mem  [WT_DEPTH];
  logic signed [bcfc_pkg::Q88_W-1:0] act_mem [MAX_IN];
  logic signed [bcfc_pkg::VAL_W-1:0] bias_mem[1 << OUT_W];

  state_t                   state_r;
  logic [bcfc_pkg::IDX_W-1:0] o_r;
  logic [LW-1:0]            k_r;
  logic [LW-1:0]            i_r;
  logic [LW-1:0]            start_r;

  logic [LW-1:0]            n_in;
  logic [LW-1:0]            n_out;
  logic                     adv;
  tag_t                     slot;
  logic [LW:0]              o_inc;
  logic [LW-1:0]            start_inc;

  logic [XW-1:0]            wr_row_x;
  logic [XW-1:0]            wr_col_x;
  logic [XW-1:0]            rd_i_x;
  logic [XW-1:0]            rd_o_x;
  logic [WT_AW-1:0]         wt_wr_addr;
  logic [WT_AW-1:0]         wt_rd_addr;

  logic                               s1_valid_r;
  tag_t                               s1_tag_r;
  logic signed [bcfc_pkg::Q88_W-1:0]  act_rd_r;
  logic signed [bcfc_pkg::Q88_W-1:0]  wt_rd_r;
  logic signed [bcfc_pkg::VAL_W-1:0]  bias_rd_r;

  logic                               s2_valid_r;
  tag_t                               s2_tag_r;
  logic signed [bcfc_pkg::VAL_W-1:0]  prod_r;
  logic signed [bcfc_pkg::VAL_W-1:0]  bias2_r;

  logic signed [bcfc_pkg::ACC_W-1:0]  acc_r;
  logic signed [bcfc_pkg::ACC_W-1:0]  base;
  logic signed [bcfc_pkg::ACC_W-1:0]  term;
  logic signed [bcfc_pkg::ACC_W-1:0]  sum;
  logic signed [bcfc_pkg::VAL_W-1:0]  sat;

  logic                               out_valid_r;
  logic [bcfc_pkg::IDX_W-1:0]         out_index_r;
  logic signed [bcfc_pkg::VAL_W-1:0]  out_value_r;
  logic                               out_last_r;

  // Clamp the lengths to the store sizes; a zero length counts as one
  always_comb begin
    if (in_len == '0) begin
      n_in = LW'(1);
    end else if (int'(in_len) > MAX_IN) begin
      n_in = LW'(MAX_IN);
    end else begin
      n_in = in_len;
    end
    if (out_len == '0) begin
      n_out = LW'(1);
    end else if (int'(out_len) > MAX_OUT) begin
      n_out = LW'(MAX_OUT);
    end else begin
      n_out = out_len;
    end
  end

  // Pipeline moves unless the result register is stalled
  assign adv   = !out_valid_r || out_res.ready;
  assign q_pop = !q_empty && (state_r == ST_IDLE);

  // Describe the slot being issued
  assign o_inc         = {1'b0, LW'(o_r)} + 1'b1;
  assign slot.first    = k_r == '0;
  assign slot.zero     = window_len == '0;
  assign slot.last     = slot.zero || ({1'b0, k_r} + 1'b1 == {1'b0, window_len});
  assign slot.row_last = slot.last && (o_inc == {1'b0, n_out});
  assign slot.o        = o_r;
  assign start_inc     = wrap_inc(start_r, n_in);

  // Issue sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      o_r     <= '0;
      k_r     <= '0;
      i_r     <= '0;
      start_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && q_head.start) begin
            state_r <= ST_RUN;
            o_r     <= '0;
            k_r     <= '0;
            i_r     <= '0;
            start_r <= '0;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (slot.last) begin
              k_r     <= '0;
              o_r     <= o_r + 1'b1;
              start_r <= start_inc;
              i_r     <= start_inc;
              if (slot.row_last) begin
                state_r <= ST_IDLE;
              end
            end else begin
              k_r <= k_r + 1'b1;
              i_r <= wrap_inc(i_r, n_in);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Store addresses
  assign wr_row_x   = XW'(q_head.row);
  assign wr_col_x   = XW'(q_head.col);
  assign rd_i_x     = XW'(i_r);
  assign rd_o_x     = XW'(o_r);
  assign wt_wr_addr = {wr_row_x[IN_W-1:0], wr_col_x[OUT_W-1:0]};
  assign wt_rd_addr = {rd_i_x[IN_W-1:0], rd_o_x[OUT_W-1:0]};

  // Write stores from queued load commands
  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr_en) begin
      case (q_head.kind)
        bcfc_pkg::CMD_WEIGHT: wt_mem[wt_wr_addr] <= q_head.value[bcfc_pkg::Q88_W-1:0];
        bcfc_pkg::CMD_BIAS:   bias_mem[wr_col_x[OUT_W-1:0]] <= q_head.value;
        bcfc_pkg::CMD_ACT:    act_mem[wr_row_x[IN_W-1:0]] <= q_head.value[bcfc_pkg::Q88_W-1:0];
        default: ;
      endcase
    end
  end

  // Read stores for the issued slot; the stage behind multiplies and carries bias and tag
  always_ff @(posedge clk) begin
    if (adv) begin
      act_rd_r  <= act_mem[rd_i_x[IN_W-1:0]];
      wt_rd_r   <= wt_mem[wt_rd_addr];
      bias_rd_r <= bias_mem[rd_o_x[OUT_W-1:0]];
      s1_tag_r  <= slot;
      prod_r    <= act_rd_r * wt_rd_r;
      bias2_r   <= bias_rd_r;
      s2_tag_r  <= s1_tag_r;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= state_r == ST_RUN;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Accumulate, bias on the first slot of each neuron
  assign base = s2_tag_r.first ? bcfc_pkg::ACC_W'(bias2_r) : acc_r;
  assign term = s2_tag_r.zero ? '0 : bcfc_pkg::ACC_W'(prod_r);
  assign sum  = base + term;

  // Saturate to the Q16.16 range
  always_comb begin
    if (!sum[bcfc_pkg::ACC_W-1] && (|sum[bcfc_pkg::ACC_W-2:bcfc_pkg::VAL_W-1])) begin
      sat = {1'b0, {(bcfc_pkg::VAL_W-1){1'b1}}};
    end else if (sum[bcfc_pkg::ACC_W-1] && !(&sum[bcfc_pkg::ACC_W-2:bcfc_pkg::VAL_W-1])) begin
      sat = {1'b1, {(bcfc_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat = sum[bcfc_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      acc_r <= sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_tag_r.last) begin
      out_index_r <= s2_tag_r.o;
      out_value_r <= sat;
      out_last_r  <= s2_tag_r.row_last;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.out_index = out_index_r;
  assign out_res.out_value = out_value_r;
  assign out_res.out_last  = out_last_r;

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_pop && q_head.start)
      |=> (state_r == ST_RUN && o_r == '0 && k_r == '0))
    else $error("row computation did not start from neuron zero");

  a_issue_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && adv) |=> s1_valid_r)
    else $error("issued slot lost before read stage");

  // A new row may still be started from idle while the result register waits
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && state_r == ST_RUN)
      |=> ($stable(s2_valid_r) && $stable(s1_valid_r) && $stable(o_r)))
    else $error("pipeline moved while result register stalled");

endmodule

// ===== sv/banded_circulant_fully_connected_unit.sv =====
// Banded circulant fully connected unit: loads weights, biases and one
// activation row, then emits one saturated Q16.16 result per neuron.
// Throughput: one load request per cycle while the command queue has room; a row runs one
// multiply-accumulate per cycle on the single weight store read port unless the output stalls.
// Slots flow through the read and product registers, then accumulate into the result register.
// Reset: lengths return to 64/64/8, queue and pipeline empty; stores keep contents.
module banded_circulant_fully_connected_unit #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bcfc_in_if.sink                        in_req,
  bcfc_out_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [bcfc_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [bcfc_pkg::LEN_W-1:0]     cfg_data
);

  logic [bcfc_pkg::LEN_W-1:0] in_len_r;
  logic [bcfc_pkg::LEN_W-1:0] out_len_r;
  logic [bcfc_pkg::LEN_W-1:0] window_len_r;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  bcfc_pkg::cmd_t q_cmd;
  bcfc_pkg::cmd_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r     <= bcfc_pkg::LEN_W'(64);
      out_len_r    <= bcfc_pkg::LEN_W'(64);
      window_len_r <= bcfc_pkg::LEN_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcfc_pkg::CFG_IN_LEN:     in_len_r     <= cfg_data;
        bcfc_pkg::CFG_OUT_LEN:    out_len_r    <= cfg_data;
        bcfc_pkg::CFG_WINDOW_LEN: window_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bcfc_front #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_front (
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  bcfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  bcfc_back #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_len     (in_len_r),
    .out_len    (out_len_r),
    .window_len (window_len_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_res    (out_res)
  );

endmodule

// ===== dv/banded_circulant_fully_connected_unit_tb.sv =====
// Self-checking bench for the banded circulant fully connected unit: loads weights,
// biases and activation rows and checks each neuron result against a predicted row.
// Depends on bcfc_pkg and the bcfc_in_if / bcfc_out_if channel interfaces.
module banded_circulant_fully_connected_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcfc_pkg::*;

  localparam int MAX_IN        = 64;
  localparam int MAX_OUT       = 64;
  localparam int ITEM_TARGET   = 500;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 20000;
  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam longint SAT_MIN   = -64'sd2147483648;
  localparam logic [OPC_W-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             done;
    bit               hold;
  } load_req_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } neuron_res_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_index;
  logic [LEN_W-1:0]   cfg_data;

  bcfc_in_if  in_if ();
  bcfc_out_if out_if ();

  banded_circulant_fully_connected_unit #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  load_req_t   pending_reqs[$];
  load_req_t   cur_req;
  bit          req_busy;
  neuron_res_t expected_neurons[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          stall_cycles;

  // Predicted contents of the block
  logic signed [Q88_W-1:0] weight_mem [MAX_IN][MAX_OUT];
  logic signed [VAL_W-1:0] bias_mem   [MAX_OUT];
  logic signed [Q88_W-1:0] act_mem    [MAX_IN];
  logic [LEN_W-1:0]        in_len_q;
  logic [LEN_W-1:0]        out_len_q;
  logic [LEN_W-1:0]        window_len_q;

  // Which entries the generated stream has written so far
  bit w_loaded [MAX_IN][MAX_OUT];
  bit b_loaded [MAX_OUT];
  bit a_loaded [MAX_IN];
  bit hold_next;
  int item_count;

  always #4 clk = ~clk;

  function automatic int clamp_len(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Apply one accepted request to the predicted stores; a row-done activation
  // request queues one saturated sum per neuron.
  task automatic predict_request(input load_req_t r);
    int          n_in;
    int          n_out;
    int          i;
    int          o;
    int          k;
    longint      acc;
    neuron_res_t res;
    case (r.opcode)
      OP_WEIGHT: weight_mem[r.row][r.col] = r.value[Q88_W-1:0];
      OP_BIAS:   bias_mem[r.col] = r.value;
      OP_ACT: begin
        act_mem[r.row] = r.value[Q88_W-1:0];
        if (r.done) begin
          n_in  = clamp_len(in_len_q, MAX_IN);
          n_out = clamp_len(out_len_q, MAX_OUT);
          for (o = 0; o < n_out; o++) begin
            acc = 0;
            i   = o % n_in;
            // walk the band, wrapping at the row length
            for (k = 0; k < window_len_q; k++) begin
              acc += longint'(act_mem[i]) * longint'(weight_mem[i][o]);
              i = (i + 1 == n_in) ? 0 : i + 1;
            end
            acc += longint'(bias_mem[o]);
            if (acc > SAT_MAX) acc = SAT_MAX;
            if (acc < SAT_MIN) acc = SAT_MIN;
            res.index = o[IDX_W-1:0];
            res.value = acc[VAL_W-1:0];
            res.last  = (o == n_out - 1);
            expected_neurons.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: retire the accepted request, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      req_busy = 1'b0;
      in_if.valid <= 1'b0;
    end else begin
      if (req_busy && in_if.ready) begin
        predict_request(cur_req);
        req_busy = 1'b0;
      end
      if (!req_busy && pending_reqs.size() != 0 &&
          !(pending_reqs[0].hold && expected_neurons.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_req  = pending_reqs.pop_front();
        req_busy = 1'b1;
        in_if.opcode    <= cur_req.opcode;
        in_if.row_index <= cur_req.row;
        in_if.col_index <= cur_req.col;
        in_if.value     <= cur_req.value;
        in_if.row_done  <= cur_req.done;
      end
      in_if.valid <= req_busy;
    end
  end

  // Monitor: compare each neuron result with the oldest prediction
  always @(posedge clk) begin
    neuron_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_neurons.size() == 0) begin
          $error("out_index: no result expected, got %0d", out_if.out_index);
          mismatches++;
        end else begin
          want = expected_neurons.pop_front();
          if (out_if.out_index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, out_if.out_index);
            mismatches++;
          end
          if (out_if.out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_if.out_value));
            mismatches++;
          end
          if (out_if.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_if.out_last);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: stop when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[Q88_W-1:0] = 16'h7FFF;
      1: v[Q88_W-1:0] = 16'h8000;
      2: v = 32'h7FFF_FFFF;
      3: v = 32'h8000_0000;
      4: v[Q88_W-1:0] = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_req(logic [OPC_W-1:0] op, int row, int col,
                          logic [VAL_W-1:0] val, bit done);
    load_req_t r;
    r.opcode = op;
    r.row    = row[IDX_W-1:0];
    r.col    = col[IDX_W-1:0];
    r.value  = val;
    r.done   = done;
    r.hold   = hold_next;
    hold_next = 1'b0;
    pending_reqs.push_back(r);
    case (op)
      OP_WEIGHT: w_loaded[row][col] = 1'b1;
      OP_BIAS:   b_loaded[col] = 1'b1;
      OP_ACT:    a_loaded[row] = 1'b1;
      default: ;
    endcase
    if (op != OP_UNUSED) item_count++;
  endtask

  // Queue one row: stray writes, a random part of the activation row, weight and bias
  // refreshes, any entry the band will read that is still unloaded, then the row-done request.
  task automatic load_row(int in_cfg, int out_cfg, int win);
    int               n_in;
    int               n_out;
    int               i;
    int               o;
    int               k;
    logic [OPC_W-1:0] op;
    n_in  = clamp_len(in_cfg, MAX_IN);
    n_out = clamp_len(out_cfg, MAX_OUT);
    repeat ($urandom_range(0, 6)) begin
      op = OPC_W'($urandom_range(0, 3));
      push_req(op, $urandom_range(0, 63), $urandom_range(0, 63), pick_value(),
               (op == OP_ACT) ? 1'b0 : 1'($urandom_range(0, 1)));
    end
    for (i = 0; i < n_in; i++)
      if ($urandom_range(0, 2) != 0)
        push_req(OP_ACT, i, $urandom_range(0, 63), pick_value(), 1'b0);
    for (o = 0; o < n_out; o++) begin
      if (win > 0 && $urandom_range(0, 3) == 0)
        push_req(OP_WEIGHT, (o + $urandom_range(0, win - 1)) % n_in, o, pick_value(),
                 1'($urandom_range(0, 1)));
      if (!b_loaded[o] || $urandom_range(0, 7) == 0)
        push_req(OP_BIAS, $urandom_range(0, 63), o, pick_value(), 1'($urandom_range(0, 1)));
      for (k = 0; k < win; k++) begin
        i = (o + k) % n_in;
        if (!w_loaded[i][o]) push_req(OP_WEIGHT, i, o, pick_value(), 1'b0);
        if (!a_loaded[i]) push_req(OP_ACT, i, $urandom_range(0, 63), pick_value(), 1'b0);
      end
    end
    push_req(OP_ACT, $urandom_range(0, 63), $urandom_range(0, 63), pick_value(), 1'b1);
  endtask

  task automatic write_cfg(logic [CFG_A_W-1:0] idx, logic [LEN_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      CFG_IN_LEN:     in_len_q = d;
      CFG_OUT_LEN:    out_len_q = d;
      CFG_WINDOW_LEN: window_len_q = d;
      default: ;
    endcase
  endtask

  task automatic set_lengths(int n_in, int n_out, int win);
    write_cfg(CFG_IN_LEN, LEN_W'(n_in));
    write_cfg(CFG_OUT_LEN, LEN_W'(n_out));
    write_cfg(CFG_WINDOW_LEN, LEN_W'(win));
    if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, LEN_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every request is in and every result is out, then let the
  // command queue and pipeline empty.
  task automatic wait_idle();
    while (req_busy || pending_reqs.size() != 0 || expected_neurons.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int rows;
    int mode;
    bit force_hold;
    int in_c;
    int out_c;
    int win_c;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.opcode    = '0;
    in_if.row_index = '0;
    in_if.col_index = '0;
    in_if.value     = '0;
    in_if.row_done  = 1'b0;
    out_if.ready    = 1'b0;
    in_len_q        = 7'd64;
    out_len_q       = 7'd64;
    window_len_q    = 7'd8;
    send_idle_pct   = 28;
    recv_idle_pct   = 47;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Window longer than the row: neuron 0 saturates high, neuron 1 low,
    // neuron 2 gives its bias alone, neuron 3 overflows a full-scale bias.
    set_lengths(3, 4, 5);
    push_req(OP_WEIGHT, 0, 0, 32'hA5A5_7FFF, 1'b0);
    push_req(OP_WEIGHT, 1, 0, 32'h0000_7FFF, 1'b0);
    push_req(OP_WEIGHT, 2, 0, 32'h0000_8000, 1'b1);
    push_req(OP_WEIGHT, 0, 1, 32'h0000_8000, 1'b0);
    push_req(OP_WEIGHT, 1, 1, 32'h7FFF_8000, 1'b0);
    push_req(OP_WEIGHT, 2, 1, 32'h0000_7FFF, 1'b0);
    push_req(OP_WEIGHT, 0, 2, 32'h0000_0000, 1'b0);
    push_req(OP_WEIGHT, 1, 2, 32'h0000_0000, 1'b0);
    push_req(OP_WEIGHT, 2, 2, 32'hFFFF_0000, 1'b0);
    push_req(OP_WEIGHT, 0, 3, 32'hFFFF_0001, 1'b0);
    push_req(OP_WEIGHT, 1, 3, 32'h0000_0001, 1'b0);
    push_req(OP_WEIGHT, 2, 3, 32'h0000_0001, 1'b0);
    push_req(OP_BIAS, 63, 0, 32'h7FFF_FFFF, 1'b1);
    push_req(OP_BIAS, 0, 1, 32'h8000_0000, 1'b0);
    push_req(OP_BIAS, 0, 2, 32'h8000_0000, 1'b0);
    push_req(OP_BIAS, 0, 3, 32'h7FFF_FFFF, 1'b0);
    push_req(OP_UNUSED, 63, 63, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_ACT, 0, 63, 32'h0000_7FFF, 1'b0);
    push_req(OP_ACT, 1, 0, 32'h5A5A_7FFF, 1'b0);
    push_req(OP_ACT, 2, 0, 32'h0000_8000, 1'b1);
    wait_idle();

    // Lengths out of range: zero row length, oversized neuron count, empty window
    write_cfg(CFG_UNUSED, 7'h7F);
    set_lengths(0, 127, 0);
    load_row(0, 127, 0);
    wait_idle();
    // Full row length and the longest window, wrapping back to the row start once
    set_lengths(127, 1, 127);
    load_row(127, 1, 127);
    wait_idle();
    // Zero neuron count
    set_lengths(5, 0, 3);
    load_row(5, 0, 3);
    load_row(5, 0, 3);
    wait_idle();

    // Random phases, each with its own lengths and a few rows; every phase
    // runs at least once
    mode       = 1;
    force_hold = 1'b1;
    while (item_count < ITEM_TARGET || mode != 3) begin
      if (mode == 1 && item_count >= 320) begin
        mode          = 2;
        send_idle_pct = 47;
        recv_idle_pct = 28;
        force_hold    = 1'b1;
      end else if (mode == 2 && item_count >= 420) begin
        mode          = 3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        force_hold    = 1'b1;
      end
      in_c  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 10);
      out_c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      win_c = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      set_lengths(in_c, out_c, win_c);
      rows = $urandom_range(2, 4);
      for (int r = 0; r < rows; r++) begin
        // pause the sender mid-phase until the previous row has drained
        if (r > 0 && (force_hold || $urandom_range(0, 9) == 0)) begin
          hold_next  = 1'b1;
          force_hold = 1'b0;
        end
        load_row(in_c, out_c, win_c);
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_neurons.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
